/* src/record_table_sort_search_defines.svh */
// Assertion macros for the record table
`ifndef RECORD_TABLE_SORT_SEARCH_DEFINES_SVH
`define RECORD_TABLE_SORT_SEARCH_DEFINES_SVH

// same-cycle implication, off during reset
`define RTSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("record table check failed");

// next-cycle implication, off during reset
`define RTSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("record table check failed");

// next-cycle implication, live through reset
`define RTSS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("record table check failed");

`endif

/* src/rtss_pkg.sv */
package rtss_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int ID_WIDTH_DEF    = 16;

  localparam int REQ_W  = 3;
  localparam int ID_W   = 16;
  localparam int ROLE_W = 2;
  localparam int IDX_W  = 6;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_MODIFY = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FIND   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SORT   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd5;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
  localparam logic [STAT_W-1:0] ST_ROLE = 2'd3;

  localparam logic [ROLE_W-1:0] ROLE_NONE = 2'd0;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ID_W-1:0]   key_id;
    logic [ID_W-1:0]   new_id;
    logic [ROLE_W-1:0] new_role;
    logic              descending;
    logic [IDX_W-1:0]  read_index;
  } req_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  found_index;
    logic [ID_W-1:0]   entry_id;
    logic [ROLE_W-1:0] entry_role;
    logic [CNT_W-1:0]  entry_count;
  } rsp_word_t;

endpackage

/* src/rtss_ram.sv */
module rtss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/record_table_sort_search.sv */
// channel | handshake           | word
// request | req_valid/req_ready | req (rtss_pkg::req_word_t)
// result  | rsp_valid/rsp_ready | rsp (rtss_pkg::rsp_word_t)
// One request at a time; all table work runs through one RAM read port, one entry a cycle.
// Append, clear, no-op, refused append or read, empty-table requests and sort under two
// entries end at dispatch. A read index does one RAM read; find/modify scan to a hit or
// the last entry; delete scans, then shifts later entries down. Sort is a selection sort
// (scan, put-i, put-pick per pass). Reset clears the count and handshakes only; no RAM sweep.
// A waiting result holds in the output register while the next request is taken.
module record_table_sort_search #(
  parameter int TABLE_DEPTH = rtss_pkg::TABLE_DEPTH_DEF,
  parameter int ID_WIDTH    = rtss_pkg::ID_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  rtss_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rtss_pkg::rsp_word_t rsp
);
  import rtss_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = ID_WIDTH + ROLE_W;
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_READ, S_SEARCH, S_SHIFT,
    S_SORT_SCAN, S_SORT_PUT_I, S_SORT_PUT_PICK, S_DONE
  } state_t;

  state_t              state;
  logic [REQ_W-1:0]    op;
  logic [ID_WIDTH-1:0] key;
  logic [ID_WIDTH-1:0] nid;
  logic [ROLE_W-1:0]   nrole;
  logic                down;
  logic [IDX_W-1:0]    ridx;
  logic [CW-1:0]       count;
  logic [CW-1:0]       ptr;
  logic                pend;
  logic [CW-1:0]       pidx;
  logic [CW-1:0]       pass_i;
  logic [AW-1:0]       pick;
  logic [EW-1:0]       best;
  logic [EW-1:0]       first;
  logic [STAT_W-1:0]   res_status;
  logic [CW-1:0]       res_pos;
  logic [ID_WIDTH-1:0] res_id;
  logic [ROLE_W-1:0]   res_role;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [EW-1:0]       wdata;
  logic [AW-1:0]       raddr;
  logic [EW-1:0]       rdata;
  logic [ID_WIDTH-1:0] rd_id;
  logic [ROLE_W-1:0]   rd_role;
  logic [ID_WIDTH-1:0] best_id;
  logic                issue;
  logic                hit;
  logic                better;
  logic                swap;
  logic [CW-1:0]       pidx_dec;
  logic [CW:0]         pass_end;

  assign req_ready = (state == S_IDLE);
  assign rd_id     = rdata[ID_WIDTH-1:0];
  assign rd_role   = rdata[EW-1 -: ROLE_W];
  assign best_id   = best[ID_WIDTH-1:0];
  assign issue     = (ptr < count);
  assign hit       = (rd_id == key);
  assign better    = down ? (best_id < rd_id) : (best_id > rd_id);
  assign swap      = (pick != pass_i[AW-1:0]);
  assign pidx_dec  = pidx - CW'(1);
  assign pass_end  = (CW+1)'(pass_i) + (CW+1)'(2);

  always_comb begin
    we    = 1'b0;
    waddr = ptr[AW-1:0];
    wdata = {nrole, nid};
    raddr = ptr[AW-1:0];
    case (state)
      S_DISPATCH: begin
        raddr = AW'(ridx);
        waddr = count[AW-1:0];
        we    = (op == REQ_APPEND) && (count < DEPTH_C) && (nrole != ROLE_NONE);
      end
      S_SEARCH: begin
        waddr = pidx[AW-1:0];
        we    = pend && hit && (op == REQ_MODIFY) && (nrole != ROLE_NONE);
      end
      S_SHIFT: begin
        waddr = pidx_dec[AW-1:0];
        wdata = rdata;
        we    = pend;
      end
      S_SORT_PUT_I: begin
        waddr = pass_i[AW-1:0];
        wdata = best;
        we    = swap;
      end
      S_SORT_PUT_PICK: begin
        waddr = pick;
        wdata = first;
        we    = swap;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  rtss_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op         <= req.req_type;
            key        <= ID_WIDTH'(req.key_id);
            nid        <= ID_WIDTH'(req.new_id);
            nrole      <= req.new_role;
            down       <= req.descending;
            ridx       <= req.read_index;
            res_status <= ST_OK;
            res_pos    <= '0;
            res_id     <= '0;
            res_role   <= '0;
            ptr        <= '0;
            pend       <= 1'b0;
            pass_i     <= '0;
            state      <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (op)
            REQ_APPEND: begin
              state <= S_DONE;
              if (count >= DEPTH_C) begin
                res_status <= ST_FULL;
              end else if (nrole == ROLE_NONE) begin
                res_status <= ST_ROLE;
              end else begin
                res_pos  <= count;
                res_id   <= nid;
                res_role <= nrole;
                count    <= count + CW'(1);
              end
            end
            REQ_DELETE, REQ_MODIFY, REQ_FIND: begin
              if (count == '0) begin
                res_status <= ST_MISS;
                state      <= S_DONE;
              end else begin
                state <= S_SEARCH;
              end
            end
            REQ_SORT: begin
              if (count > CW'(1)) begin
                state <= S_SORT_SCAN;
              end else begin
                state <= S_DONE;
              end
            end
            REQ_READ: begin
              if (XW'(ridx) >= XW'(count)) begin
                res_status <= ST_MISS;
                state      <= S_DONE;
              end else begin
                state <= S_READ;
              end
            end
            REQ_CLEAR: begin
              count <= '0;
              state <= S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_READ: begin
          res_pos  <= CW'(ridx);
          res_id   <= rd_id;
          res_role <= rd_role;
          state    <= S_DONE;
        end
        S_SEARCH: begin
          pidx <= ptr;
          if (pend && hit) begin
            res_pos <= pidx;
            if (op == REQ_DELETE) begin
              res_id   <= rd_id;
              res_role <= rd_role;
              ptr      <= pidx + CW'(1);
              pend     <= 1'b0;
              state    <= S_SHIFT;
            end else if ((op == REQ_MODIFY) && (nrole != ROLE_NONE)) begin
              res_id   <= nid;
              res_role <= nrole;
              state    <= S_DONE;
            end else begin
              res_id   <= rd_id;
              res_role <= rd_role;
              if (op == REQ_MODIFY) begin
                res_status <= ST_ROLE;
              end
              state <= S_DONE;
            end
          end else begin
            pend <= issue;
            if (issue) begin
              ptr <= ptr + CW'(1);
            end
            if (pend && (pidx == count - CW'(1))) begin
              res_status <= ST_MISS;
              state      <= S_DONE;
            end
          end
        end
        S_SHIFT: begin
          pend <= issue;
          pidx <= ptr;
          if (issue) begin
            ptr <= ptr + CW'(1);
          end
          if (!issue && !pend) begin
            count <= count - CW'(1);
            state <= S_DONE;
          end
        end
        S_SORT_SCAN: begin
          pend <= issue;
          pidx <= ptr;
          if (issue) begin
            ptr <= ptr + CW'(1);
          end
          if (pend) begin
            if (pidx == pass_i) begin
              best  <= rdata;
              first <= rdata;
              pick  <= pidx[AW-1:0];
            end else if (better) begin
              best <= rdata;
              pick <= pidx[AW-1:0];
            end
          end
          if (!issue && !pend) begin
            state <= S_SORT_PUT_I;
          end
        end
        S_SORT_PUT_I: begin
          state <= S_SORT_PUT_PICK;
        end
        S_SORT_PUT_PICK: begin
          pass_i <= pass_i + CW'(1);
          ptr    <= pass_i + CW'(1);
          pend   <= 1'b0;
          if (pass_end >= (CW+1)'(count)) begin
            state <= S_DONE;
          end else begin
            state <= S_SORT_SCAN;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.status        <= res_status;
            rsp.found_index   <= IDX_W'(res_pos);
            rsp.entry_id      <= ID_W'(res_id);
            rsp.entry_role    <= res_role;
            rsp.entry_count   <= CNT_W'(count);
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/rtss_checker.sv */
`include "record_table_sort_search_defines.svh"

module rtss_checker #(
  parameter int TABLE_DEPTH = rtss_pkg::TABLE_DEPTH_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input rtss_pkg::req_word_t req,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input rtss_pkg::rsp_word_t rsp
);
  import rtss_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  logic refused;
  logic blank;
  assign refused = rsp_valid && (rsp.status == ST_MISS || rsp.status == ST_FULL);
  assign blank   = rsp.found_index == '0 && rsp.entry_id == '0 && rsp.entry_role == '0;

  `RTSS_ASSERT_RST(a_rst_quiet, rst, !rsp_valid)
  `RTSS_ASSERT_NXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req))
  `RTSS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
  `RTSS_ASSERT_IMP(a_refused_blank, refused, blank)
  `RTSS_ASSERT_IMP(a_full_count, rsp_valid && rsp.status == ST_FULL, rsp.entry_count == FULL_CNT)

endmodule

bind record_table_sort_search rtss_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_rtss_checker (.*);
